[sv/tlsb_pkg.sv]
`default_nettype none
package tlsb_pkg;
  localparam int HistLines = 256;
  localparam int MaxCols = 128;
  localparam int SlotW = $clog2(HistLines);
  localparam int ColW = $clog2(MaxCols);
  localparam int CntW = SlotW + 1;

  localparam logic [2:0] ActPut = 3'd0;
  localparam logic [2:0] ActUp = 3'd1;
  localparam logic [2:0] ActDown = 3'd2;
  localparam logic [2:0] ActClear = 3'd3;
  localparam logic [2:0] ActRead = 3'd4;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegRows = 2'd1;
  localparam logic [1:0] RegPrompt = 2'd2;

  localparam logic [7:0] ChBs = 8'd8;
  localparam logic [7:0] ChTab = 8'd9;
  localparam logic [7:0] ChNl = 8'd10;
  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChDel = 8'd127;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item
    logic exec;       // apply put, scroll, clear, read address
    logic copy_start; // begin a line copy
    logic copy_step;  // one cell of line copy
    logic copy_done;  // finish commit bookkeeping
    logic finish;     // drive result
  } tlsb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_commit;
    logic copy_last;
    logic tab_more;
  } tlsb_sts_t;
endpackage
`default_nettype wire

[sv/tlsb_ctrl.sv]
`default_nettype none
module tlsb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire tlsb_pkg::tlsb_sts_t sts,
  output tlsb_pkg::tlsb_cmd_t   cmd,
  output logic                  busy
);
  import tlsb_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_TAB, S_COPY, S_DONE, S_OUT} state_t;
  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) state <= S_EXEC;
        S_EXEC: begin
          if (sts.need_commit) state <= S_COPY;
          else if (sts.tab_more) state <= S_TAB;
          else state <= S_OUT;
        end
        S_TAB:  if (!sts.tab_more) state <= S_OUT;
        S_COPY: if (sts.copy_last) state <= S_DONE;
        S_DONE: state <= S_OUT;
        S_OUT:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && start;
    cmd.copy_start = (state == S_EXEC) && sts.need_commit;
    cmd.exec = ((state == S_EXEC) && !sts.need_commit) || (state == S_TAB) ||
               (state == S_DONE);
    cmd.copy_step = (state == S_COPY);
    cmd.copy_done = (state == S_COPY) && sts.copy_last;
    cmd.finish = (state == S_OUT);
  end
  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

[sv/tlsb_dp.sv]
`default_nettype none
module tlsb_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tlsb_pkg::tlsb_cmd_t cmd,
  output tlsb_pkg::tlsb_sts_t      sts,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  input  wire logic [2:0]          action,
  input  wire logic [7:0]          char_in,
  input  wire logic [15:0]         scroll_amount,
  input  wire logic [5:0]          cell_row,
  input  wire logic [6:0]          cell_col,
  output logic                     done,
  output logic [7:0]               cell_char,
  output logic                     line_committed,
  output logic [8:0]               stored_lines,
  output logic [8:0]               scroll_now,
  output logic [6:0]               partial_length
);
  import tlsb_pkg::*;

  logic [7:0] line_width;
  logic [6:0] screen_rows;
  logic       prompt_on;

  logic [2:0]  act_q;
  logic [7:0]  ch_q;
  logic [15:0] amt_q;
  logic [5:0]  row_q;
  logic [6:0]  col_q;

  logic [ColW:0]   ppos;
  logic [SlotW-1:0] head, tail;
  logic [CntW-1:0] total, scroll;
  logic             committed;

  logic [7:0] pline [MaxCols];
  logic [7:0] hist [HistLines*MaxCols];

  logic [ColW:0] ccnt;
  logic [ColW:0] cn;
  logic [7:0]    pl_rd;
  logic [7:0]    hist_rd;
  logic          rd_valid;
  logic          rd_space;

  // copy pipeline: the partial line read is registered ahead of the history write
  logic [SlotW-1:0] wr_slot;
  logic [ColW-1:0]  wr_col;
  logic             wr_en;
  logic             wr_keep;

  // effective config
  logic [ColW+1:0] cols;
  logic [6:0]      rows;
  always_comb begin
    if (line_width < 8'd2) cols = (ColW+2)'(2);
    else if ({1'b0, line_width} > 9'(MaxCols)) cols = (ColW+2)'(MaxCols);
    else cols = (ColW+2)'(line_width);
    if (screen_rows == 7'd0) rows = 7'd1;
    else if (screen_rows > 7'd64) rows = 7'd64;
    else rows = screen_rows;
  end

  logic [ColW+1:0] wrapc;
  assign wrapc = cols - 1'b1;
  logic at_wrap;
  assign at_wrap = {1'b0, ppos} >= wrapc;
  logic is_ctl;
  assign is_ctl = (ch_q == ChBs) || (ch_q == ChTab) || (ch_q == ChNl) || (ch_q == ChCr);
  logic printable;
  assign printable = (ch_q >= ChSpace) && (ch_q < ChDel);

  assign sts.need_commit = (act_q == ActPut) &&
    (((ch_q == ChNl) && (ppos != '0)) || (!is_ctl && at_wrap));
  assign sts.copy_last = (ccnt == (ColW+1)'(MaxCols - 1));

  // tab pads one space per cycle until a multiple of 4 or the wrap column
  assign sts.tab_more = (act_q == ActPut) && (ch_q == ChTab) && !at_wrap &&
                        (ppos[1:0] != 2'b11);

  // read address
  logic [6:0]  vis;
  logic signed [CntW+2:0] idx;
  assign vis = rows - 7'(prompt_on);
  assign idx = $signed({3'b0, total}) - $signed({3'b0, scroll}) -
               $signed((CntW+3)'(vis)) + $signed((CntW+3)'(row_q));
  logic [SlotW-1:0] rslot;
  assign rslot = head + SlotW'(idx);
  logic rd_ok;
  assign rd_ok = ({1'b0, row_q} < vis) && ((ColW+2)'(col_q) < cols) &&
                 !idx[CntW+2] && (idx < $signed((CntW+3)'(total)));

  assign cn = ({1'b0, ppos} < cols) ? ppos : (ColW+1)'(cols);

  logic [CntW+15:0] sum_up;
  assign sum_up = (CntW+16)'(scroll) + (CntW+16)'(amt_q);

  logic [CntW-1:0] lim;
  assign lim = (total > CntW'(rows)) ? total - CntW'(rows) : '0;

  always_ff @(posedge clk) begin
    pl_rd <= pline[ccnt[ColW-1:0]];
    wr_slot <= tail;
    wr_col <= ccnt[ColW-1:0];
    wr_keep <= (ccnt < cn);
    if (wr_en) begin
      hist[{wr_slot, wr_col}] <= wr_keep ? pl_rd : 8'd0;
    end
    hist_rd <= hist[{rslot, col_q}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 8'd80;
      screen_rows <= 7'd25;
      prompt_on <= 1'b0;
      ppos <= '0;
      head <= '0;
      tail <= '0;
      total <= '0;
      scroll <= '0;
      committed <= 1'b0;
      ccnt <= '0;
      done <= 1'b0;
      rd_valid <= 1'b0;
      rd_space <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      done <= cmd.finish;
      wr_en <= cmd.copy_step;
      if (cfg_we) begin
        unique case (cfg_index)
          RegWidth:  line_width <= cfg_data;
          RegRows:   screen_rows <= cfg_data[6:0];
          RegPrompt: prompt_on <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        act_q <= action;
        ch_q <= char_in;
        amt_q <= scroll_amount;
        row_q <= cell_row;
        col_q <= cell_col;
        committed <= 1'b0;
        rd_valid <= 1'b0;
        rd_space <= 1'b0;
      end
      if (cmd.copy_start) ccnt <= '0;
      if (cmd.copy_step) ccnt <= ccnt + 1'b1;
      if (cmd.copy_done) begin
        if (total >= CntW'(HistLines)) begin
          head <= head + 1'b1;
          total <= total;
        end else begin
          total <= total + 1'b1;
        end
        tail <= tail + 1'b1;
        committed <= 1'b1;
        scroll <= '0;
        // newline ends here; wrap commit continues with the byte
        if (ch_q == ChNl) begin
          ppos <= '0;
          ch_q <= ChCr;
        end else begin
          ppos <= '0;
        end
      end
      if (cmd.exec) begin
        unique case (act_q)
          ActPut: begin
            if (ch_q == ChNl) begin
              scroll <= '0;
              ppos <= '0;
            end else if (ch_q == ChCr) begin
              if (!committed) ppos <= '0;
            end else if (ch_q == ChTab) begin
              if (!at_wrap) begin
                pline[ppos[ColW-1:0]] <= ChSpace;
                ppos <= ppos + 1'b1;
              end
            end else if (ch_q == ChBs) begin
              if (ppos != '0) ppos <= ppos - 1'b1;
            end else if (printable) begin
              pline[ppos[ColW-1:0]] <= ch_q;
              ppos <= ppos + 1'b1;
            end
          end
          ActUp: scroll <= (sum_up > (CntW+16)'(lim)) ? lim : CntW'(sum_up);
          ActDown: scroll <= ((CntW+16)'(scroll) < (CntW+16)'(amt_q)) ? '0 :
                             scroll - CntW'(amt_q);
          ActClear: begin
            head <= '0;
            tail <= '0;
            total <= '0;
            scroll <= '0;
          end
          ActRead: begin
            rd_valid <= rd_ok;
            rd_space <= !rd_ok;
          end
          default: ;
        endcase
      end
    end
  end

  assign cell_char = rd_valid ? hist_rd : (rd_space ? ChSpace : 8'd0);
  assign line_committed = committed;
  assign stored_lines = 9'(total);
  assign scroll_now = 9'(scroll);
  assign partial_length = 7'(ppos);
endmodule
`default_nettype wire

[sv/text_line_scrollback_buffer.sv]
`default_nettype none
// channel   | signals                                         | dir
// config    | cfg_we, cfg_index, cfg_data                     | in
// command   | start, action, char_in, scroll_amount,          | in
//           | cell_row, cell_col                              |
// result    | busy, done, cell_char, line_committed,          | out
//           | stored_lines, scroll_now, partial_length        |
// an item passes capture, execute and result from start to done; a tab pads further
// spaces after the first, and a line commit copies a whole line: the line copy writes
// one history cell per cycle through the single write port of the history memory
// busy stays high from acceptance until done; done is a one-cycle strobe
// synchronous reset clears the ring counters, scroll and partial position
// the receiver cannot stall; line_committed holds until the next item is captured
module text_line_scrollback_buffer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  char_in,
  input  wire logic [15:0] scroll_amount,
  input  wire logic [5:0]  cell_row,
  input  wire logic [6:0]  cell_col,
  output logic             done,
  output logic [7:0]       cell_char,
  output logic             line_committed,
  output logic [8:0]       stored_lines,
  output logic [8:0]       scroll_now,
  output logic [6:0]       partial_length
);
  import tlsb_pkg::*;

  tlsb_cmd_t cmd;
  tlsb_sts_t sts;

  // sequencer: capture, execute, tab padding, optional line copy, result
  tlsb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  // partial line, history ring, scroll and read path
  tlsb_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .action(action), .char_in(char_in), .scroll_amount(scroll_amount),
    .cell_row(cell_row), .cell_col(cell_col),
    .done(done), .cell_char(cell_char), .line_committed(line_committed),
    .stored_lines(stored_lines), .scroll_now(scroll_now),
    .partial_length(partial_length)
  );

`ifndef SYNTH
  // a result only appears for an item in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("done without busy item");
  // history never exceeds the ring
  a_total: assert property (@(posedge clk) disable iff (rst) stored_lines <= 9'd256)
    else $error("history count overflow");
  // scroll zero after a commit
  a_scroll: assert property (@(posedge clk) disable iff (rst)
    (done && line_committed) |-> (scroll_now == 9'd0))
    else $error("scroll not reset by commit");
`endif
endmodule
`default_nettype wire
